/* rtl/lsacn_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line sensor ambient cancel and normalize: shared definitions
// Field widths, parameter defaults, register indexes and reset values.
// ----------------------------------------------------------------------------
package lsacn_pkg;

    localparam int NUM_CHANNELS_DEF = 12;
    localparam int AVG_SHIFT_DEF    = 2;
    localparam int SAMPLE_BITS_DEF  = 12;

    localparam int CHAN_W     = 4;
    localparam int CHAN_EXT_W = CHAN_W + 1;
    localparam int FS_W       = 16;
    localparam int QUOT_W     = 16;
    localparam int DIGIT_W    = 4;
    localparam int CFG_AW     = 3;
    localparam int CFG_DW     = 32;

    localparam logic [FS_W-1:0] FULL_SCALE_RST = 16'd1000;
    localparam logic [1:0]      BOTH_READY     = 2'b11;

    typedef enum logic {
        REG_CAL_MODE   = 1'b0,
        REG_FULL_SCALE = 1'b1
    } reg_idx_t;

endpackage
`default_nettype wire

/* rtl/lsacn_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lsacn_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/lsacn_norm.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Normalization unit
// Computes (offset * full_scale + span/2) / span with a digit-serial
// multiplier (one 4-bit digit of full_scale per cycle) followed by a
// restoring divider that retires one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lsacn_norm #(
    parameter int SAMPLE_BITS = lsacn_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [SAMPLE_BITS-1:0]        offset,
    input  wire logic [SAMPLE_BITS-1:0]        span,
    input  wire logic [lsacn_pkg::FS_W-1:0]    full_scale,
    output logic                               done,
    output logic      [lsacn_pkg::QUOT_W-1:0]  quotient
);
    import lsacn_pkg::*;

    localparam int NUM_W     = SAMPLE_BITS + QUOT_W;
    localparam int MUL_STEPS = FS_W / DIGIT_W;
    localparam int CNT_W     = $clog2(QUOT_W);
    localparam int PART_W    = SAMPLE_BITS + DIGIT_W;

    typedef enum logic [3:0] {
        N_IDLE = 4'b0001,
        N_MUL  = 4'b0010,
        N_RND  = 4'b0100,
        N_DIV  = 4'b1000
    } nstate_t;

    nstate_t                state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic                   done_reg, done_next;
    logic [SAMPLE_BITS-1:0] off_reg, span_reg;
    logic [FS_W-1:0]        dig_reg;
    logic [NUM_W-1:0]       prod_reg;
    logic [SAMPLE_BITS-1:0] rem_reg;
    logic [QUOT_W-1:0]      quo_reg;

    logic [PART_W-1:0]      partial;
    logic [NUM_W-1:0]       num;
    logic [SAMPLE_BITS:0]   trial;
    logic [SAMPLE_BITS:0]   diff;
    logic                   ge;

    assign partial = off_reg * dig_reg[FS_W-1 -: DIGIT_W];
    assign num     = prod_reg + NUM_W'(span_reg >> 1);
    assign trial   = {rem_reg, quo_reg[QUOT_W-1]};
    assign diff    = trial - {1'b0, span_reg};
    assign ge      = trial >= {1'b0, span_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    state_next = N_MUL;
                    cnt_next   = '0;
                end
            end
            N_MUL: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) begin
                    state_next = N_RND;
                end
            end
            N_RND: begin
                state_next = N_DIV;
                cnt_next   = '0;
            end
            N_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(QUOT_W - 1)) begin
                    state_next = N_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                state_next = N_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= N_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    // The top part of the numerator is below the span because the offset is,
    // so the quotient needs exactly QUOT_W restoring steps.
    always_ff @(posedge aclk) begin
        case (state_reg)
            N_IDLE: begin
                if (start) begin
                    off_reg  <= offset;
                    span_reg <= span;
                    dig_reg  <= full_scale;
                    prod_reg <= '0;
                end
            end
            N_MUL: begin
                prod_reg <= (prod_reg << DIGIT_W) + NUM_W'(partial);
                dig_reg  <= dig_reg << DIGIT_W;
            end
            N_RND: begin
                rem_reg <= num[NUM_W-1 -: SAMPLE_BITS];
                quo_reg <= num[QUOT_W-1:0];
            end
            N_DIV: begin
                rem_reg <= ge ? diff[SAMPLE_BITS-1:0] : trial[SAMPLE_BITS-1:0];
                quo_reg <= {quo_reg[QUOT_W-2:0], ge};
            end
            default: begin
                prod_reg <= prod_reg;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule
`default_nettype wire

/* rtl/line_sensor_ambient_cancel_normalize.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Line sensor ambient cancel and normalize
// Averages lit and dark samples per channel over a window of frames, emits
// the dark-minus-lit level and its min/max normalization to full_scale.
//
//   Port group   Direction  Content
//   s_axis       in         one converter sample word per channel
//   m_axis       out        level, normalized value, channel, calibrated flag
//   APB          in/out     cal_mode (0x0), full_scale (0x4)
//
// A word that produces no result occupies the block for the accept cycle
// and one pass through the accumulator and average RAMs. A word that closes
// a window with a result also occupies it through the min/max update, the
// span check and, when the divider runs, the digit multiplier and restoring
// divider of lsacn_norm; the divider is skipped when the span is missing or
// the level saturates. Reset is synchronous; RAM entries are tracked with
// valid bits, so no clearing pass follows it. A stalled result word waits in
// the output register while the next input word is processed.
// ----------------------------------------------------------------------------
module line_sensor_ambient_cancel_normalize #(
    parameter int NUM_CHANNELS = lsacn_pkg::NUM_CHANNELS_DEF,
    parameter int AVG_SHIFT    = lsacn_pkg::AVG_SHIFT_DEF,
    parameter int SAMPLE_BITS  = lsacn_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // s_tdata: sample
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]     s_tdata,
    // s_tuser: led_on, channel
    input  wire logic [lsacn_pkg::CHAN_W:0]           s_tuser,
    input  wire logic                                 s_tlast,
    input  wire logic                                 s_tvalid,
    output logic                                      s_tready,
    // m_tdata: level, normalized
    output logic [((SAMPLE_BITS+lsacn_pkg::FS_W+7)/8)*8-1:0] m_tdata,
    // m_tuser: out_channel, calibrated
    output logic [lsacn_pkg::CHAN_W:0]                m_tuser,
    output logic                                      m_tvalid,
    input  wire logic                                 m_tready,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [lsacn_pkg::CFG_AW-1:0]         paddr,
    input  wire logic [lsacn_pkg::CFG_DW-1:0]         pwdata,
    output logic      [lsacn_pkg::CFG_DW-1:0]         prdata,
    output logic                                      pready
);
    import lsacn_pkg::*;

    localparam int CH_IDX_W  = $clog2(NUM_CHANNELS);
    localparam int RAM_AW    = CH_IDX_W + 1;
    localparam int RAM_DEPTH = 2 ** RAM_AW;
    localparam int ACC_W     = SAMPLE_BITS + AVG_SHIFT;
    localparam int FCNT_W    = (AVG_SHIFT > 0) ? AVG_SHIFT : 1;
    localparam int M_DATA_W  = ((SAMPLE_BITS + FS_W + 7) / 8) * 8;
    localparam logic [FCNT_W-1:0] LAST_FRAME = FCNT_W'((1 << AVG_SHIFT) - 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_READ   = 6'b000010,
        S_MINMAX = 6'b000100,
        S_SPAN   = 6'b001000,
        S_NORM   = 6'b010000,
        S_DONE   = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    // Configuration registers
    logic            cal_mode_reg;
    logic [FS_W-1:0] fs_reg;
    logic            cfg_wr;

    // Latched input word
    logic                   phase_reg;
    logic [CHAN_W-1:0]      ch_reg;
    logic [SAMPLE_BITS-1:0] smp_reg;
    logic                   fend_reg;

    // Window state
    logic [FCNT_W-1:0]      fcnt_reg [2];
    logic [1:0]             rb_reg;
    logic [1:0]             rb_set;
    logic [RAM_DEPTH-1:0]   acc_vld_reg;
    logic [RAM_DEPTH-1:0]   avg_vld_reg;
    logic [SAMPLE_BITS-1:0] max_reg [NUM_CHANNELS];
    logic [SAMPLE_BITS-1:0] min_reg [NUM_CHANNELS];

    // Result path
    logic [SAMPLE_BITS-1:0] level_reg;
    logic [FS_W-1:0]        norm_reg;
    logic                   cal_reg;
    logic                   out_vld_reg;
    logic [SAMPLE_BITS-1:0] level_out_reg;
    logic [FS_W-1:0]        norm_out_reg;
    logic [CHAN_W-1:0]      chan_out_reg;
    logic                   cal_out_reg;

    // Input side
    logic                   in_acc;
    logic                   in_led;
    logic [CHAN_EXT_W-1:0]  in_ch_ext;
    logic [RAM_AW-1:0]      acc_raddr, avg_raddr;

    // Read pass
    logic [CHAN_EXT_W-1:0]  ch_ext;
    logic [CH_IDX_W-1:0]    ch_idx;
    logic [RAM_AW-1:0]      addr_own, addr_oth;
    logic [ACC_W-1:0]       acc_rdata, acc_old, acc_sum, acc_wdata;
    logic [SAMPLE_BITS-1:0] avg_rdata, oth_avg, new_avg;
    logic [SAMPLE_BITS-1:0] dark, lit, lvl;
    logic                   in_range, last, emit;
    logic                   acc_we, avg_we;

    // Span pass
    logic [SAMPLE_BITS-1:0] lo, hi, span, offset;
    logic                   span_ok, cal_next, sat;
    logic                   norm_start, norm_done;
    logic [QUOT_W-1:0]      norm_quot;
    logic                   out_load;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cal_mode_reg <= 1'b0;
            fs_reg       <= FULL_SCALE_RST;
        end else if (cfg_wr) begin
            case (reg_idx_t'(paddr[2]))
                REG_CAL_MODE:   cal_mode_reg <= pwdata[0];
                REG_FULL_SCALE: fs_reg       <= pwdata[FS_W-1:0];
                default:        cal_mode_reg <= cal_mode_reg;
            endcase
        end
    end

    always_comb begin
        case (reg_idx_t'(paddr[2]))
            REG_CAL_MODE:   prdata = CFG_DW'(cal_mode_reg);
            REG_FULL_SCALE: prdata = CFG_DW'(fs_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Input word and RAM reads
    // ------------------------------------------------------------------
    assign s_tready  = (state_reg == S_IDLE);
    assign in_acc    = s_tvalid && s_tready;
    assign in_led    = s_tuser[0];
    assign in_ch_ext = {1'b0, s_tuser[CHAN_W:1]};
    assign acc_raddr = {in_led, in_ch_ext[CH_IDX_W-1:0]};
    assign avg_raddr = {~in_led, in_ch_ext[CH_IDX_W-1:0]};

    always_ff @(posedge aclk) begin
        if (in_acc) begin
            phase_reg <= in_led;
            ch_reg    <= s_tuser[CHAN_W:1];
            smp_reg   <= s_tdata[SAMPLE_BITS-1:0];
            fend_reg  <= s_tlast;
        end
    end

    lsacn_ram #(
        .WIDTH (ACC_W),
        .DEPTH (RAM_DEPTH)
    ) u_acc_ram (
        .aclk  (aclk),
        .we    (acc_we),
        .waddr (addr_own),
        .wdata (acc_wdata),
        .raddr (acc_raddr),
        .rdata (acc_rdata)
    );

    lsacn_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (RAM_DEPTH)
    ) u_avg_ram (
        .aclk  (aclk),
        .we    (avg_we),
        .waddr (addr_own),
        .wdata (new_avg),
        .raddr (avg_raddr),
        .rdata (avg_rdata)
    );

    // ------------------------------------------------------------------
    // Accumulate, close the window and form the level
    // ------------------------------------------------------------------
    assign ch_ext   = {1'b0, ch_reg};
    assign ch_idx   = ch_ext[CH_IDX_W-1:0];
    assign addr_own = {phase_reg, ch_idx};
    assign addr_oth = {~phase_reg, ch_idx};
    assign in_range = 32'(ch_ext) < 32'(NUM_CHANNELS);
    assign last     = fcnt_reg[phase_reg] >= LAST_FRAME;

    assign acc_old   = acc_vld_reg[addr_own] ? acc_rdata : '0;
    assign acc_sum   = acc_old + ACC_W'(smp_reg);
    assign new_avg   = acc_sum[AVG_SHIFT +: SAMPLE_BITS];
    assign acc_wdata = last ? '0 : acc_sum;
    assign oth_avg   = avg_vld_reg[addr_oth] ? avg_rdata : '0;

    assign dark = phase_reg ? oth_avg : new_avg;
    assign lit  = phase_reg ? new_avg : oth_avg;
    assign lvl  = (dark > lit) ? dark - lit : '0;

    assign acc_we = (state_reg == S_READ) && in_range;
    assign avg_we = acc_we && last;
    assign emit   = avg_we && rb_reg[~phase_reg];
    assign rb_set = rb_reg | (2'b01 << phase_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_vld_reg <= '0;
            avg_vld_reg <= '0;
            rb_reg      <= '0;
            fcnt_reg[0] <= '0;
            fcnt_reg[1] <= '0;
        end else if (state_reg == S_READ) begin
            if (acc_we) begin
                acc_vld_reg[addr_own] <= 1'b1;
            end
            if (avg_we) begin
                avg_vld_reg[addr_own] <= 1'b1;
            end
            // The emit decision above uses the ready bits before this update.
            if (fend_reg) begin
                if (last) begin
                    fcnt_reg[phase_reg] <= '0;
                    rb_reg <= (rb_set == BOTH_READY) ? 2'b00 : rb_set;
                end else begin
                    fcnt_reg[phase_reg] <= fcnt_reg[phase_reg] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            level_reg <= lvl;
        end
    end

    // ------------------------------------------------------------------
    // Calibration and normalization
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                max_reg[i] <= '0;
                min_reg[i] <= '1;
            end
        end else if (state_reg == S_MINMAX && cal_mode_reg) begin
            if (level_reg > max_reg[ch_idx]) begin
                max_reg[ch_idx] <= level_reg;
            end
            if (level_reg < min_reg[ch_idx]) begin
                min_reg[ch_idx] <= level_reg;
            end
        end
    end

    assign lo       = min_reg[ch_idx];
    assign hi       = max_reg[ch_idx];
    assign span_ok  = hi > lo;
    assign cal_next = span_ok && (FS_W'(hi) <= fs_reg);
    assign span     = hi - lo;
    assign offset   = (level_reg > lo) ? level_reg - lo : '0;
    assign sat      = offset >= span;

    assign norm_start = (state_reg == S_SPAN) && span_ok && !sat;

    lsacn_norm #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_norm (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (norm_start),
        .offset     (offset),
        .span       (span),
        .full_scale (fs_reg),
        .done       (norm_done),
        .quotient   (norm_quot)
    );

    always_ff @(posedge aclk) begin
        if (state_reg == S_SPAN) begin
            cal_reg <= cal_next;
            if (!span_ok) begin
                norm_reg <= FS_W'(level_reg);
            end else if (sat) begin
                norm_reg <= fs_reg;
            end
        end else if (state_reg == S_NORM && norm_done) begin
            norm_reg <= norm_quot;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    assign out_load = (state_reg == S_DONE) && (!out_vld_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                state_next = emit ? S_MINMAX : S_IDLE;
            end
            S_MINMAX: begin
                state_next = S_SPAN;
            end
            S_SPAN: begin
                state_next = norm_start ? S_NORM : S_DONE;
            end
            S_NORM: begin
                if (norm_done) begin
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            level_out_reg <= level_reg;
            norm_out_reg  <= norm_reg;
            chan_out_reg  <= ch_reg;
            cal_out_reg   <= cal_reg;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = M_DATA_W'({norm_out_reg, level_out_reg});
    assign m_tuser  = {cal_out_reg, chan_out_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_not_both: assert property (@(posedge aclk) disable iff (!aresetn)
        rb_reg != BOTH_READY)
        else $error("both phase ready bits left set after a window update");

    a_fcnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (fcnt_reg[0] <= LAST_FRAME) && (fcnt_reg[1] <= LAST_FRAME))
        else $error("frame count ran past the last frame of the window");

    a_accept_reads: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> (state_reg == S_READ))
        else $error("accepted word did not enter the RAM pass");

    a_done_in_norm: assert property (@(posedge aclk) disable iff (!aresetn)
        norm_done |-> (state_reg == S_NORM))
        else $error("divider finished while the sequencer was not waiting");

    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |-> (!out_vld_reg || m_tready))
        else $error("output register overwritten while holding a word");

endmodule
`default_nettype wire

/* test/tb_line_sensor_ambient_cancel_normalize.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for line_sensor_ambient_cancel_normalize
// Drives converter sample words through the stream input and predicts each
// level word from a behavioral copy of the phase averaging, dark-minus-lit
// cancellation and min/max normalization. The run walks several cal_mode and
// full_scale settings with random idling on both sides, and reports any
// missing, extra or wrong level word.
// ----------------------------------------------------------------------------
module tb_line_sensor_ambient_cancel_normalize;

    import lsacn_pkg::*;

    localparam int NCH        = NUM_CHANNELS_DEF;
    localparam int SHIFT      = AVG_SHIFT_DEF;
    localparam int SMP_W      = SAMPLE_BITS_DEF;
    localparam int ACC_W      = SMP_W + SHIFT;
    localparam int FRAMES     = 1 << SHIFT;
    localparam int SETTLE     = 40;
    localparam int LONG_HOLD  = 400;
    localparam int STALL_MAX  = 4000;
    localparam int PHASE_ITEMS = 80;
    localparam int NUM_SETTINGS = 6;

    typedef struct packed {
        logic [CHAN_W-1:0] chan;
        logic [SMP_W-1:0]  level;
        logic [FS_W-1:0]   norm;
        logic              cal;
    } level_word_t;

    class level_scoreboard;
        level_word_t levels_due[$];
        int          mismatches;
        bit          cal_mode;
        bit [FS_W-1:0] full_scale;
        bit [ACC_W-1:0] acc_sum [2][NCH];
        bit [SMP_W-1:0] avg_level [2][NCH];
        bit [5:0]       frame_cnt [2];
        bit [1:0]       ready;
        bit [SMP_W-1:0] ch_max [NCH];
        bit [SMP_W-1:0] ch_min [NCH];

        function new();
            mismatches = 0;
            cal_mode   = 1'b0;
            full_scale = FULL_SCALE_RST;
            ready      = '0;
            frame_cnt  = '{default: '0};
            foreach (acc_sum[p, c]) begin
                acc_sum[p][c]   = '0;
                avg_level[p][c] = '0;
            end
            foreach (ch_max[c]) begin
                ch_max[c] = '0;
                ch_min[c] = '1;
            end
        endfunction

        function void set_reg(reg_idx_t idx, bit [CFG_DW-1:0] value);
            case (idx)
                REG_CAL_MODE:   cal_mode = value[0];
                REG_FULL_SCALE: full_scale = value[FS_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return levels_due.size();
        endfunction

        task report(string msg);
            $display("%0t ns: %s", $realtime, msg);
            mismatches++;
        endtask

        function void scale_level(int ch, bit [SMP_W-1:0] level,
                                  output bit [FS_W-1:0] norm, output bit cal);
            longint unsigned lo, hi, span, offset;
            if (cal_mode) begin
                if (level > ch_max[ch]) ch_max[ch] = level;
                if (level < ch_min[ch]) ch_min[ch] = level;
            end
            lo = ch_min[ch];
            hi = ch_max[ch];
            cal = (hi > lo) && (hi <= full_scale);
            if (hi > lo) begin
                span   = hi - lo;
                offset = (level > lo) ? level - lo : 0;
                if (offset >= span)
                    norm = full_scale;
                else
                    norm = FS_W'((offset * full_scale + span / 2) / span);
            end else begin
                norm = FS_W'(level);
            end
        endfunction

        // Updates the phase state for one accepted sample and queues the
        // level word it closes, if any.
        function void accept_sample(bit led, bit [CHAN_W-1:0] ch,
                                    bit [SMP_W-1:0] smp, bit fend);
            bit             last;
            bit [ACC_W-1:0] sum;
            bit [SMP_W-1:0] dark, lit;
            level_word_t    w;
            last = frame_cnt[led] >= FRAMES - 1;
            if (ch < NCH) begin
                sum = acc_sum[led][ch] + ACC_W'(smp);
                if (last) begin
                    avg_level[led][ch] = SMP_W'(sum >> SHIFT);
                    acc_sum[led][ch]   = '0;
                    if (ready[led ^ 1'b1]) begin
                        dark    = avg_level[0][ch];
                        lit     = avg_level[1][ch];
                        w.chan  = ch;
                        w.level = (dark > lit) ? dark - lit : '0;
                        scale_level(ch, w.level, w.norm, w.cal);
                        levels_due.push_back(w);
                    end
                end else begin
                    acc_sum[led][ch] = sum;
                end
            end
            if (fend) begin
                if (last) begin
                    frame_cnt[led] = '0;
                    ready[led] = 1'b1;
                    if (ready == BOTH_READY) ready = '0;
                end else begin
                    frame_cnt[led] = frame_cnt[led] + 1'b1;
                end
            end
        endfunction

        task check_level_word(bit [31:0] tdata, bit [CHAN_W:0] tuser);
            level_word_t got, want;
            got.chan  = tuser[CHAN_W-1:0];
            got.cal   = tuser[CHAN_W];
            got.level = tdata[SMP_W-1:0];
            got.norm  = tdata[SMP_W +: FS_W];
            if (levels_due.size() == 0) begin
                report($sformatf("unexpected level word ch %0d level %0d",
                                 got.chan, got.level));
            end else begin
                want = levels_due.pop_front();
                if (got.chan != want.chan)
                    report($sformatf("channel %0d, want %0d", got.chan, want.chan));
                if (got.level != want.level)
                    report($sformatf("ch %0d level %0d, want %0d",
                                     want.chan, got.level, want.level));
                if (got.norm != want.norm)
                    report($sformatf("ch %0d normalized %0d, want %0d",
                                     want.chan, got.norm, want.norm));
                if (got.cal != want.cal)
                    report($sformatf("ch %0d calibrated %0d, want %0d",
                                     want.chan, got.cal, want.cal));
            end
        endtask
    endclass

    logic                 aclk;
    logic                 aresetn;
    logic [15:0]          s_tdata;   // sample
    logic [CHAN_W:0]      s_tuser;   // led_on, channel
    logic                 s_tlast;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [31:0]          m_tdata;   // level, normalized
    logic [CHAN_W:0]      m_tuser;   // out_channel, calibrated
    logic                 m_tvalid;
    logic                 m_tready;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [CFG_AW-1:0]    paddr;
    logic [CFG_DW-1:0]    pwdata;
    logic [CFG_DW-1:0]    prdata;
    logic                 pready;

    level_scoreboard board = new();
    int  samples_sent;
    int  quiet_cycles;
    bit  tx_idle;
    bit  rx_idle;
    bit  long_hold_req;

    line_sensor_ambient_cancel_normalize u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    // Accepted words on both sides go to the scoreboard; a long run of cycles
    // without any accepted word ends the run.
    always @(posedge aclk) begin
        if (!aresetn) begin
            quiet_cycles <= 0;
        end else begin
            if (s_tvalid && s_tready)
                board.accept_sample(s_tuser[0], s_tuser[CHAN_W:1], s_tdata[SMP_W-1:0],
                                    s_tlast);
            if (m_tvalid && m_tready)
                board.check_level_word(m_tdata, m_tuser);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_MAX) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Result side: a random stall before each word while rx_idle is set, with one long hold on request.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = rx_idle ? $urandom_range(0, 11) : 0;
            if (long_hold_req) begin
                stall = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    task automatic send_sample(bit led, bit [CHAN_W-1:0] ch, bit [SMP_W-1:0] smp,
                               bit fend);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tdata  = 16'(smp);
        s_tuser  = {ch, led};
        s_tlast  = fend;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
        gap = tx_idle ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    // Stops offering words and waits until every level word has arrived and
    // the block has had time to finish any word that closes nothing.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (board.pending() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(reg_idx_t idx, bit [CFG_DW-1:0] value);
        @(negedge aclk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        board.set_reg(idx, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // One lit window and one dark window in random order, each FRAMES frames
    // of all channels. A broken pair stops early. Now and then a channel is
    // left out of a frame or sent twice.
    task automatic send_window_pair(bit broken);
        int          ceiling, frames, r;
        bit          first, led;
        bit [CHAN_W-1:0] chans[$];
        bit [SMP_W-1:0]  smp;
        first   = 1'($urandom_range(0, 1));
        frames  = broken ? $urandom_range(1, 2 * FRAMES - 1) : 2 * FRAMES;
        r       = $urandom_range(0, 2);
        ceiling = (r == 0) ? 4095 : (r == 1) ? 1023 : 255;
        tx_idle = $urandom_range(0, 2) != 0;
        rx_idle = $urandom_range(0, 2) != 0;
        for (int f = 0; f < frames; f++) begin
            led = (f < FRAMES) ? first : ~first;
            chans.delete();
            for (int c = 0; c < NCH; c++) begin
                r = $urandom_range(0, 19);
                if (r != 0) chans.push_back(CHAN_W'(c));
                if (r == 1) chans.push_back(CHAN_W'(c));
            end
            if (chans.size() == 0) chans.push_back('0);
            foreach (chans[i]) begin
                // Dark readings run higher than lit ones most of the time.
                smp = led ? SMP_W'($urandom_range(0, ceiling / 2))
                          : SMP_W'($urandom_range(0, ceiling));
                send_sample(led, chans[i], smp, i == chans.size() - 1);
            end
        end
    endtask

    task automatic send_noise(int count);
        tx_idle = 1'($urandom_range(0, 1));
        for (int i = 0; i < count; i++)
            send_sample(1'($urandom_range(0, 1)), CHAN_W'($urandom_range(0, 15)),
                        SMP_W'($urandom_range(0, 4095)), $urandom_range(0, 3) == 0);
    endtask

    initial begin
        bit        cal_set [NUM_SETTINGS];
        bit [15:0] fs_set  [NUM_SETTINGS];
        int        start, r;
        cal_set       = '{1, 1, 0, 1, 0, 1};
        fs_set        = '{16'd1000, 16'd65535, 16'd1, 16'd0, 16'd4095, 16'd300};
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = '0;
        s_tlast       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        samples_sent  = 0;
        tx_idle       = 1'b0;
        rx_idle       = 1'b0;
        long_hold_req = 1'b0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        write_reg(REG_CAL_MODE, 32'(cal_set[0]));
        write_reg(REG_FULL_SCALE, 32'(fs_set[0]));

        // Directed: full-scale readings, a repeated channel, out-of-range
        // channels carrying the frame end, a channel missing from the dark
        // window, a clamped level, and one-sample frames.
        send_sample(0, 0, 12'hFFF, 0);
        send_sample(0, 11, 12'hFFF, 0);
        send_sample(0, 11, 12'hFFF, 0);
        send_sample(0, 15, 12'h07B, 1);
        send_sample(0, 12, 12'h000, 1);
        send_sample(0, 0, 12'hFFF, 1);
        send_sample(0, 0, 12'hFFF, 0);
        send_sample(0, 11, 12'hFFF, 1);
        send_sample(1, 0, 12'h000, 1);
        send_sample(1, 0, 12'h000, 1);
        send_sample(1, 0, 12'h000, 1);
        send_sample(1, 0, 12'h000, 0);
        send_sample(1, 11, 12'hFFF, 0);
        send_sample(1, 3, 12'h000, 1);
        drain();

        for (int s = 0; s < NUM_SETTINGS; s++) begin
            if (s > 0) begin
                write_reg(REG_CAL_MODE, 32'(cal_set[s]));
                write_reg(REG_FULL_SCALE, 32'(fs_set[s]));
            end
            // In the second setting the result side holds off long enough
            // for the block to back up into its input.
            if (s == 1) long_hold_req = 1'b1;
            start = samples_sent;
            while (samples_sent - start < PHASE_ITEMS) begin
                r = $urandom_range(0, 9);
                if (r < 7)
                    send_window_pair(1'b0);
                else if (r == 7)
                    send_window_pair(1'b1);
                else
                    send_noise($urandom_range(1, 12));
            end
            drain();
        end

        if (board.pending() != 0)
            board.report($sformatf("%0d level words never arrived", board.pending()));
        if (board.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
